FILE: sv/bvavg_pkg.sv
// Shared constants, codes and controller/datapath types for the battery voltage averager.
`timescale 1ns / 1ps

package bvavg_pkg;

    localparam int ADC_W       = 10;
    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = 13;
    localparam int FILL_W      = 12;
    localparam int SUM_W       = ADC_W + FILL_W;
    localparam int SUP_W       = 21;
    localparam int INV_W       = 16;
    localparam int BIAS_W      = 16;
    localparam int SCALE_W     = 16;
    localparam int VOLT_W      = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 21;

    localparam int PROD_W      = SUM_W + SUP_W;
    localparam int ACC_W       = PROD_W + INV_W;
    localparam int FRAC_SHIFT  = 18;
    localparam int MV_W        = ACC_W - FRAC_SHIFT;
    localparam int DIFF_W      = MV_W + 2;
    localparam int CAL_SHIFT   = 12;
    localparam int DIV_W       = DIFF_W - 1 + CAL_SHIFT;
    localparam int DEN_W       = 16;
    localparam int STEP_W      = $clog2(DIV_W + 1);

    localparam int MEAN_MAX     = 2 ** ADC_W - 1;
    localparam int VOLT_MAX     = 2 ** (VOLT_W - 1) - 1;
    localparam int VOLT_MIN_MAG = 2 ** (VOLT_W - 1);

    localparam int RST_REF_CONST = 1125300;
    localparam int RST_COUNT     = 500;
    localparam int RST_INV       = 1280;
    localparam int RST_BIAS      = 0;
    localparam int RST_SCALE     = 4096;

    localparam logic CMD_REF  = 1'b0;
    localparam logic CMD_BATT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_CONST = 3'd0,
        CFG_COUNT     = 3'd1,
        CFG_INV       = 3'd2,
        CFG_BIAS      = 3'd3,
        CFG_SCALE     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REF_DIV,
        ST_MEAN_GO,
        ST_MEAN_DIV,
        ST_MUL_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MV_GO,
        ST_MV_DIV,
        ST_CAL_GO,
        ST_CAL_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_REF,
        DIV_MEAN,
        DIV_MV,
        DIV_CAL
    } t_div_sel;

    typedef enum logic [1:0] {
        MUL_SUM,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        logic     div_start;
        t_div_sel div_sel;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ref_store;
        logic     mean_store;
        logic     diff_store;
        logic     volt_store;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_is_ref;
        logic win_last;
        logic div_done;
        logic supply_zero;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/bvavg_in_if.sv
// Input channel: ADC conversion items with valid/ready handshake.
`timescale 1ns / 1ps

interface bvavg_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [bvavg_pkg::ADC_W-1:0] adc_value;

    modport source (output valid, output command, output adc_value, input ready);
    modport sink   (input valid, input command, input adc_value, output ready);
endinterface

FILE: sv/bvavg_out_if.sv
// Output channel: averaged voltage result items with valid/ready handshake.
`timescale 1ns / 1ps

interface bvavg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bvavg_pkg::VOLT_W-1:0] voltage_mv;
    logic        [bvavg_pkg::SUP_W-1:0]  supply_mv;
    logic        [bvavg_pkg::ADC_W-1:0]  mean_raw;
    logic                                status;

    modport source (output valid, output voltage_mv, output supply_mv, output mean_raw,
                    output status, input ready);
    modport sink   (input valid, input voltage_mv, input supply_mv, input mean_raw,
                    input status, output ready);
endinterface

FILE: sv/bvavg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bvavg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bvavg_pkg::DIV_W-1:0] i_num,
    input  logic [bvavg_pkg::DEN_W-1:0] i_den,
    output logic                        o_done,
    output logic [bvavg_pkg::DIV_W-1:0] o_quo
);

    logic [bvavg_pkg::DEN_W-1:0]  r_rem;
    logic [bvavg_pkg::DEN_W-1:0]  r_den;
    logic [bvavg_pkg::DIV_W-1:0]  r_quo;
    logic [bvavg_pkg::STEP_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [bvavg_pkg::DEN_W:0]    trial_in;
    logic [bvavg_pkg::DEN_W:0]    trial;
    logic                         take;

    assign trial_in = {r_rem, r_quo[bvavg_pkg::DIV_W-1]};
    assign trial    = trial_in - {1'b0, r_den};
    assign take     = trial_in >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bvavg_pkg::STEP_W'(bvavg_pkg::DIV_W);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= take ? trial[bvavg_pkg::DEN_W-1:0] : trial_in[bvavg_pkg::DEN_W-1:0];
                r_quo <= {r_quo[bvavg_pkg::DIV_W-2:0], take};
                r_cnt <= r_cnt - bvavg_pkg::STEP_W'(1);
                if (r_cnt == bvavg_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/bvavg_ctrl.sv
// Sequencing state machine: window bookkeeping, divisions, multiplies and result hand-off.
`timescale 1ns / 1ps

module bvavg_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bvavg_pkg::t_dp_status  i_status,
    output bvavg_pkg::t_dp_cmd     o_cmd
);

    bvavg_pkg::t_state r_state;
    bvavg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvavg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = bvavg_pkg::DIV_REF;
        o_cmd.mul_sel = bvavg_pkg::MUL_SUM;
        unique case (r_state)
            bvavg_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    if (i_status.in_is_ref) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = bvavg_pkg::DIV_REF;
                        n_state         = bvavg_pkg::ST_REF_DIV;
                    end else if (i_status.win_last) begin
                        n_state = bvavg_pkg::ST_MEAN_GO;
                    end
                end
            end
            bvavg_pkg::ST_REF_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.ref_store = 1'b1;
                    n_state         = bvavg_pkg::ST_IDLE;
                end
            end
            bvavg_pkg::ST_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bvavg_pkg::DIV_MEAN;
                n_state         = bvavg_pkg::ST_MEAN_DIV;
            end
            bvavg_pkg::ST_MEAN_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.mean_store = 1'b1;
                    n_state = i_status.supply_zero ? bvavg_pkg::ST_OUT : bvavg_pkg::ST_MUL_SUM;
                end
            end
            bvavg_pkg::ST_MUL_SUM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bvavg_pkg::MUL_SUM;
                n_state       = bvavg_pkg::ST_MUL_LO;
            end
            bvavg_pkg::ST_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bvavg_pkg::MUL_LO;
                n_state       = bvavg_pkg::ST_MUL_HI;
            end
            bvavg_pkg::ST_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bvavg_pkg::MUL_HI;
                n_state       = bvavg_pkg::ST_MV_GO;
            end
            bvavg_pkg::ST_MV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bvavg_pkg::DIV_MV;
                n_state         = bvavg_pkg::ST_MV_DIV;
            end
            bvavg_pkg::ST_MV_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.diff_store = 1'b1;
                    n_state          = bvavg_pkg::ST_CAL_GO;
                end
            end
            bvavg_pkg::ST_CAL_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bvavg_pkg::DIV_CAL;
                n_state         = bvavg_pkg::ST_CAL_DIV;
            end
            bvavg_pkg::ST_CAL_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.volt_store = 1'b1;
                    n_state          = bvavg_pkg::ST_OUT;
                end
            end
            bvavg_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bvavg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bvavg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bvavg_dp.sv
// Datapath: configuration registers, window accumulator, multiplier, divider and result register.
`timescale 1ns / 1ps

module bvavg_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bvavg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bvavg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bvavg_pkg::t_dp_cmd               i_cmd,
    output bvavg_pkg::t_dp_status            o_status,
    bvavg_in_if.sink                         i_sample,
    bvavg_out_if.source                      o_result
);

    // configuration
    logic [bvavg_pkg::SUP_W-1:0]   r_ref_const;
    logic [bvavg_pkg::CNT_W-1:0]   r_count;
    logic [bvavg_pkg::INV_W-1:0]   r_inv;
    logic [bvavg_pkg::BIAS_W-1:0]  r_bias;
    logic [bvavg_pkg::SCALE_W-1:0] r_scale;

    // window and working state
    logic [bvavg_pkg::SUP_W-1:0]  r_supply;
    logic [bvavg_pkg::SUM_W-1:0]  r_sum;
    logic [bvavg_pkg::FILL_W-1:0] r_fill;
    logic [bvavg_pkg::SUM_W-1:0]  r_wsum;
    logic                         r_ref_zero;
    logic [bvavg_pkg::PROD_W-1:0] r_prod;
    logic [bvavg_pkg::ACC_W-1:0]  r_acc;
    logic [bvavg_pkg::DIFF_W-1:0] r_diff;
    logic [bvavg_pkg::ADC_W-1:0]  r_mean;
    logic [bvavg_pkg::VOLT_W-1:0] r_volt;

    // result register
    logic                         r_out_valid;
    logic [bvavg_pkg::VOLT_W-1:0] r_out_volt;
    logic [bvavg_pkg::SUP_W-1:0]  r_out_supply;
    logic [bvavg_pkg::ADC_W-1:0]  r_out_mean;
    logic                         r_out_status;

    logic                          sample_accept;
    logic [bvavg_pkg::CNT_W-1:0]   count_eff;
    logic [bvavg_pkg::SCALE_W-1:0] scale_eff;
    logic [bvavg_pkg::CNT_W-1:0]   fill_inc;
    logic [bvavg_pkg::SUM_W-1:0]   sum_add;
    logic                          win_last;
    logic                          supply_zero;
    logic                          out_free;
    logic [bvavg_pkg::SUM_W-1:0]   mul_a;
    logic [bvavg_pkg::SUP_W-1:0]   mul_b;
    logic [bvavg_pkg::PROD_W-1:0]  mul_p;
    logic [bvavg_pkg::DIFF_W-1:0]  diff;
    logic [bvavg_pkg::DIFF_W-1:0]  mag;
    logic [bvavg_pkg::DIV_W-1:0]   div_num;
    logic [bvavg_pkg::DEN_W-1:0]   div_den;
    logic                          div_done;
    logic [bvavg_pkg::DIV_W-1:0]   div_quo;
    logic [bvavg_pkg::ADC_W-1:0]   mean_sat;
    logic [bvavg_pkg::VOLT_W-1:0]  volt_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_const <= bvavg_pkg::SUP_W'(bvavg_pkg::RST_REF_CONST);
            r_count     <= bvavg_pkg::CNT_W'(bvavg_pkg::RST_COUNT);
            r_inv       <= bvavg_pkg::INV_W'(bvavg_pkg::RST_INV);
            r_bias      <= bvavg_pkg::BIAS_W'(bvavg_pkg::RST_BIAS);
            r_scale     <= bvavg_pkg::SCALE_W'(bvavg_pkg::RST_SCALE);
        end else if (i_cfg_we) begin
            unique case (bvavg_pkg::t_cfg_idx'(i_cfg_idx))
                bvavg_pkg::CFG_REF_CONST: r_ref_const <= i_cfg_data[bvavg_pkg::SUP_W-1:0];
                bvavg_pkg::CFG_COUNT:     r_count     <= i_cfg_data[bvavg_pkg::CNT_W-1:0];
                bvavg_pkg::CFG_INV:       r_inv       <= i_cfg_data[bvavg_pkg::INV_W-1:0];
                bvavg_pkg::CFG_BIAS:      r_bias      <= i_cfg_data[bvavg_pkg::BIAS_W-1:0];
                bvavg_pkg::CFG_SCALE:     r_scale     <= i_cfg_data[bvavg_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_count == '0) begin
            count_eff = bvavg_pkg::CNT_W'(1);
        end else if (r_count > bvavg_pkg::CNT_W'(bvavg_pkg::MAX_SAMPLES)) begin
            count_eff = bvavg_pkg::CNT_W'(bvavg_pkg::MAX_SAMPLES);
        end else begin
            count_eff = r_count;
        end
    end

    assign scale_eff     = (r_scale == '0) ? bvavg_pkg::SCALE_W'(1) : r_scale;
    assign sample_accept = i_sample.valid && i_cmd.in_ready;
    assign fill_inc      = {1'b0, r_fill} + bvavg_pkg::CNT_W'(1);
    assign sum_add       = r_sum + bvavg_pkg::SUM_W'(i_sample.adc_value);
    assign win_last      = !(fill_inc < count_eff);
    assign supply_zero   = (r_supply == '0);
    assign out_free      = !r_out_valid || o_result.ready;

    // window accumulation and supply estimate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= '0;
            r_sum    <= '0;
            r_fill   <= '0;
        end else begin
            if (sample_accept) begin
                if (i_sample.command == bvavg_pkg::CMD_REF) begin
                    r_sum      <= '0;
                    r_fill     <= '0;
                    r_ref_zero <= (i_sample.adc_value == '0);
                end else if (win_last) begin
                    r_sum  <= '0;
                    r_fill <= '0;
                    r_wsum <= sum_add;
                end else begin
                    r_sum  <= sum_add;
                    r_fill <= fill_inc[bvavg_pkg::FILL_W-1:0];
                end
            end
            if (i_cmd.ref_store) begin
                r_supply <= r_ref_zero ? '0 : div_quo[bvavg_pkg::SUP_W-1:0];
            end
        end
    end

    // shared multiplier: sum x supply, then the product x inverse ratio in two halves
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            bvavg_pkg::MUL_SUM: begin
                mul_a = r_wsum;
                mul_b = r_supply;
            end
            bvavg_pkg::MUL_LO: begin
                mul_a = r_prod[bvavg_pkg::SUM_W-1:0];
                mul_b = bvavg_pkg::SUP_W'(r_inv);
            end
            bvavg_pkg::MUL_HI: begin
                mul_a = bvavg_pkg::SUM_W'(r_prod[bvavg_pkg::PROD_W-1:bvavg_pkg::SUM_W]);
                mul_b = bvavg_pkg::SUP_W'(r_inv);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                bvavg_pkg::MUL_SUM: r_prod <= mul_p;
                bvavg_pkg::MUL_LO:  r_acc  <= bvavg_pkg::ACC_W'(mul_p);
                bvavg_pkg::MUL_HI:  r_acc  <= r_acc + (bvavg_pkg::ACC_W'(mul_p) << bvavg_pkg::SUM_W);
                default: ;
            endcase
        end
    end

    // divider operand selection
    assign mag = r_diff[bvavg_pkg::DIFF_W-1] ? (~r_diff + bvavg_pkg::DIFF_W'(1)) : r_diff;

    always_comb begin
        div_num = '0;
        div_den = '0;
        unique case (i_cmd.div_sel)
            bvavg_pkg::DIV_REF: begin
                div_num = bvavg_pkg::DIV_W'(r_ref_const);
                div_den = bvavg_pkg::DEN_W'(i_sample.adc_value);
            end
            bvavg_pkg::DIV_MEAN: begin
                div_num = bvavg_pkg::DIV_W'(r_wsum);
                div_den = bvavg_pkg::DEN_W'(count_eff);
            end
            bvavg_pkg::DIV_MV: begin
                div_num = bvavg_pkg::DIV_W'(r_acc[bvavg_pkg::ACC_W-1:bvavg_pkg::FRAC_SHIFT]);
                div_den = bvavg_pkg::DEN_W'(count_eff);
            end
            bvavg_pkg::DIV_CAL: begin
                div_num = {mag[bvavg_pkg::DIFF_W-2:0], {bvavg_pkg::CAL_SHIFT{1'b0}}};
                div_den = bvavg_pkg::DEN_W'(scale_eff);
            end
            default: ;
        endcase
    end

    bvavg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // post-division steps
    assign diff = {2'b00, div_quo[bvavg_pkg::MV_W-1:0]}
                - {{(bvavg_pkg::DIFF_W - bvavg_pkg::BIAS_W){r_bias[bvavg_pkg::BIAS_W-1]}}, r_bias};

    assign mean_sat = (div_quo > bvavg_pkg::DIV_W'(bvavg_pkg::MEAN_MAX))
                    ? bvavg_pkg::ADC_W'(bvavg_pkg::MEAN_MAX) : div_quo[bvavg_pkg::ADC_W-1:0];

    always_comb begin
        if (!r_diff[bvavg_pkg::DIFF_W-1]) begin
            if (div_quo > bvavg_pkg::DIV_W'(bvavg_pkg::VOLT_MAX)) begin
                volt_sat = bvavg_pkg::VOLT_W'(bvavg_pkg::VOLT_MAX);
            end else begin
                volt_sat = div_quo[bvavg_pkg::VOLT_W-1:0];
            end
        end else begin
            if (div_quo > bvavg_pkg::DIV_W'(bvavg_pkg::VOLT_MIN_MAG)) begin
                volt_sat = bvavg_pkg::VOLT_W'(bvavg_pkg::VOLT_MIN_MAG);
            end else begin
                volt_sat = ~div_quo[bvavg_pkg::VOLT_W-1:0] + bvavg_pkg::VOLT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_store) begin
            r_mean <= mean_sat;
        end
        if (i_cmd.diff_store) begin
            r_diff <= diff;
        end
        if (i_cmd.volt_store) begin
            r_volt <= volt_sat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_volt   <= supply_zero ? '0 : r_volt;
            r_out_supply <= r_supply;
            r_out_mean   <= r_mean;
            r_out_status <= supply_zero;
        end
    end

    assign i_sample.ready      = i_cmd.in_ready;
    assign o_result.valid      = r_out_valid;
    assign o_result.voltage_mv = r_out_volt;
    assign o_result.supply_mv  = r_out_supply;
    assign o_result.mean_raw   = r_out_mean;
    assign o_result.status     = r_out_status;

    assign o_status.in_valid    = i_sample.valid;
    assign o_status.in_is_ref   = (i_sample.command == bvavg_pkg::CMD_REF);
    assign o_status.win_last    = win_last;
    assign o_status.div_done    = div_done;
    assign o_status.supply_zero = supply_zero;
    assign o_status.out_free    = out_free;

endmodule

FILE: sv/battery_voltage_averager.sv
// Top level of the battery voltage averager: controller plus datapath.
// Usage:
//  i_sample carries ADC items: command 0 is a bandgap reading that sets the supply
//  estimate (ref_constant / adc_value) and restarts the window; command 1 is a
//  battery sample added to the window. After sample_count samples one item leaves
//  on o_result: calibrated voltage, supply estimate, raw mean and status.
//  Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Timing:
//  A battery sample that does not close the window leaves the controller idle, so
//  the next sample can follow. A bandgap item holds i_sample.ready low for one
//  54-step division. A closing sample starts up to three 54-step divisions on the
//  shared divider plus the multiply states ST_MUL_SUM, ST_MUL_LO and ST_MUL_HI, or
//  only the mean division without a usable reference; ready stays low meanwhile.
// Reset (synchronous, i_rst_n low): registers return to their defaults, the
//  window is empty and there is no reference, so results report status 1.
// Stall: the result waits in an output register; new samples are still taken,
//  and only a further closing window waits until the result has been taken.
`timescale 1ns / 1ps

module battery_voltage_averager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bvavg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bvavg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bvavg_in_if.sink                         i_sample,
    bvavg_out_if.source                      o_result
);

    bvavg_pkg::t_dp_cmd    dp_cmd;
    bvavg_pkg::t_dp_status dp_status;

    bvavg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    bvavg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_sample   (i_sample),
        .o_result   (o_result)
    );

endmodule
